>>> hdl/sfr_pkg.sv
// Shared types, constants and helpers for the stream find-and-replace block.
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 4;
  localparam int WORD_W      = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int REP_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN     = 2'd0,
    REG_PATTERN_LEN = 2'd1,
    REG_REPLACE     = 2'd2,
    REG_REPLACE_LEN = 2'd3
  } cfg_reg_t;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic emit_buf;
    logic append;
    logic emit_repl;
    logic repl_clear;
    logic shift_pat;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic can_push;
    logic out_free;
    logic len_zero;
    logic len_one;
    logic stale;
    logic plen_zero;
    logic win_match;
    logic full_match;
    logic rlen_zero;
    logic repl_last;
    logic empty_f;
    logic ending_f;
    logic hold_full;
  } sts_t;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] l);
    clamp_len = (l > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : l;
  endfunction

endpackage

>>> hdl/sfr_if.sv
// Channel interfaces: text input, result output and register write port.
interface sfr_in_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              line_end;
  logic              empty_line;
  modport source (output valid, text_byte, line_end, empty_line, input ready);
  modport sink   (input valid, text_byte, line_end, empty_line, output ready);
endinterface

interface sfr_out_if;
  import sfr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              line_done;
  logic              last;
  modport source (output valid, out_byte, byte_valid, line_done, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, line_done, last, output ready);
endinterface

interface sfr_cfg_if;
  import sfr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [WORD_W-1:0]    wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> hdl/sfr_dp.sv
// Datapath: registers, match buffer, window compare and output staging.
module sfr_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sfr_pkg::cmd_t             cmd,
  output sfr_pkg::sts_t             sts,
  input  logic [sfr_pkg::BYTE_W-1:0] in_byte,
  input  logic                      in_line_end,
  input  logic                      in_empty,
  sfr_cfg_if.sink                   cfg,
  sfr_out_if.source                 dout
);
  import sfr_pkg::*;

  logic [WORD_W-1:0]    pat_r, rep_r;
  logic [LEN_W-1:0]     plen_r, rlen_r;
  logic [WORD_W-1:0]    buf_r, buf_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [BYTE_W-1:0]    byte_r;
  logic                 empty_r, ending_r;
  logic [REP_IDX_W-1:0] idx_r, idx_nxt;
  logic [BYTE_W-1:0]    hold_r, hold_nxt;
  logic                 hold_full_r, hold_full_nxt;
  logic                 ov_r, ov_nxt;
  logic [BYTE_W-1:0]    ob_r, ob_nxt;
  logic                 obv_r, obv_nxt, old_r, old_nxt, olast_r, olast_nxt;

  logic [LEN_W-1:0]     plen_e, rlen_e, win_len;
  logic [MAX_PATTERN-1:0] eq, mask;
  logic [BYTE_W-1:0]    rep_byte, push_byte;
  logic                 push, out_free;

  assign plen_e  = clamp_len(plen_r);
  assign rlen_e  = clamp_len(rlen_r);
  assign win_len = (len_r < plen_e) ? len_r : plen_e;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq[i]   = buf_r[i*BYTE_W +: BYTE_W] == pat_r[i*BYTE_W +: BYTE_W];
      mask[i] = LEN_W'(i) < win_len;
    end
  end

  assign rep_byte  = rep_r[{idx_r, 3'b000} +: BYTE_W];
  assign push      = cmd.emit_buf | cmd.emit_repl;
  assign push_byte = cmd.emit_repl ? rep_byte : buf_r[BYTE_W-1:0];
  assign out_free  = !ov_r || dout.ready;

  assign sts.can_push   = !hold_full_r || out_free;
  assign sts.out_free   = out_free;
  assign sts.len_zero   = len_r == '0;
  assign sts.len_one    = len_r == LEN_W'(1);
  assign sts.stale      = (len_r != '0) && (len_r >= plen_e);
  assign sts.plen_zero  = plen_e == '0;
  assign sts.win_match  = &(eq | ~mask);
  assign sts.full_match = len_r >= plen_e;
  assign sts.rlen_zero  = rlen_e == '0;
  assign sts.repl_last  = {1'b0, idx_r} == (rlen_e - LEN_W'(1));
  assign sts.empty_f    = empty_r;
  assign sts.ending_f   = ending_r;
  assign sts.hold_full  = hold_full_r;

  assign cfg.ready       = 1'b1;
  assign dout.valid      = ov_r;
  assign dout.out_byte   = ob_r;
  assign dout.byte_valid = obv_r;
  assign dout.line_done  = old_r;
  assign dout.last       = olast_r;

  always_comb begin
    buf_nxt = buf_r;
    len_nxt = len_r;
    if (cmd.emit_buf) begin
      buf_nxt = buf_r >> BYTE_W;
      len_nxt = len_r - LEN_W'(1);
    end else if (cmd.append) begin
      buf_nxt = buf_r | (WORD_W'(byte_r) << {len_r[2:0], 3'b000});
      len_nxt = len_r + LEN_W'(1);
    end else if (cmd.shift_pat) begin
      buf_nxt = buf_r >> {plen_e, 3'b000};
      len_nxt = len_r - plen_e;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.repl_clear)     idx_nxt = '0;
    else if (cmd.emit_repl) idx_nxt = idx_r + REP_IDX_W'(1);
  end

  always_comb begin
    hold_nxt      = hold_r;
    hold_full_nxt = hold_full_r;
    ov_nxt        = ov_r && !dout.ready;
    ob_nxt        = ob_r;
    obv_nxt       = obv_r;
    old_nxt       = old_r;
    olast_nxt     = olast_r;
    if (push) begin
      hold_nxt      = push_byte;
      hold_full_nxt = 1'b1;
      if (hold_full_r) begin
        ov_nxt    = 1'b1;
        ob_nxt    = hold_r;
        obv_nxt   = 1'b1;
        old_nxt   = 1'b0;
        olast_nxt = 1'b0;
      end
    end else if (cmd.finish) begin
      hold_full_nxt = 1'b0;
      ov_nxt        = 1'b1;
      ob_nxt        = hold_full_r ? hold_r : '0;
      obv_nxt       = hold_full_r;
      old_nxt       = ending_r;
      olast_nxt     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r       <= '0;
      plen_r      <= '0;
      rep_r       <= '0;
      rlen_r      <= '0;
      buf_r       <= '0;
      len_r       <= '0;
      hold_full_r <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg_reg_t'(cfg.reg_index))
          REG_PATTERN:     pat_r  <= cfg.wdata;
          REG_PATTERN_LEN: plen_r <= cfg.wdata[LEN_W-1:0];
          REG_REPLACE:     rep_r  <= cfg.wdata;
          REG_REPLACE_LEN: rlen_r <= cfg.wdata[LEN_W-1:0];
        endcase
      end
      buf_r       <= buf_nxt;
      len_r       <= len_nxt;
      hold_full_r <= hold_full_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      byte_r   <= in_byte;
      empty_r  <= in_empty;
      ending_r <= in_empty | in_line_end;
    end
    idx_r   <= idx_nxt;
    hold_r  <= hold_nxt;
    ob_r    <= ob_nxt;
    obv_r   <= obv_nxt;
    old_r   <= old_nxt;
    olast_r <= olast_nxt;
  end

endmodule

>>> hdl/sfr_ctrl.sv
// Controller: sequences flush, append, scan, replacement and line close per item.
module sfr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfr_pkg::sts_t sts,
  output sfr_pkg::cmd_t cmd
);
  import sfr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_STALE, S_APPEND, S_SCAN, S_REPL, S_FLUSH, S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  state_t after_scan;

  assign in_ready   = state_r == S_IDLE;
  assign after_scan = sts.ending_f ? S_FLUSH : S_FINISH;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_PRE;
        end
      end
      S_PRE: begin
        state_nxt = sts.stale ? S_STALE : S_APPEND;
      end
      S_STALE: begin
        if (sts.can_push) begin
          cmd.emit_buf = 1'b1;
          if (sts.len_one) state_nxt = S_APPEND;
        end
      end
      S_APPEND: begin
        if (sts.empty_f) begin
          state_nxt = S_FLUSH;
        end else begin
          cmd.append = 1'b1;
          state_nxt  = S_SCAN;
        end
      end
      S_SCAN: begin
        priority if (sts.len_zero) begin
          state_nxt = after_scan;
        end else if (sts.plen_zero || !sts.win_match) begin
          if (sts.can_push) cmd.emit_buf = 1'b1;
        end else if (sts.full_match) begin
          if (sts.rlen_zero) begin
            cmd.shift_pat = 1'b1;
          end else begin
            cmd.repl_clear = 1'b1;
            state_nxt      = S_REPL;
          end
        end else begin
          state_nxt = after_scan;
        end
      end
      S_REPL: begin
        if (sts.can_push) begin
          cmd.emit_repl = 1'b1;
          if (sts.repl_last) begin
            cmd.shift_pat = 1'b1;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        if (sts.len_zero) begin
          state_nxt = S_FINISH;
        end else if (sts.can_push) begin
          cmd.emit_buf = 1'b1;
        end
      end
      S_FINISH: begin
        if (!sts.hold_full && !sts.ending_f) begin
          state_nxt = S_IDLE;
        end else if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/stream_find_replace.sv
// Top level of the streaming find-and-replace block.
//
//  channel   dir  handshake         payload
//  in_chan   in   valid / ready     text_byte, line_end, empty_line
//  out_chan  out  valid / ready     out_byte, byte_valid, line_done, last
//  cfg_chan  in   valid / ready     reg_index, wdata (always ready)
//
//  An item passes accept, stale check, append, final scan and close; on top of these it
//  sends each byte, handles each pattern match found and runs a flush check at line end;
//  an empty line skips the scan. One output push per cycle, when the output has room.
//  Reset: rst_n synchronous, clears registers, buffer and handshake state.
//  Out stalls hold the sequence; the next item is taken while the closing result waits.
module stream_find_replace (
  input  logic       clk,
  input  logic       rst_n,
  sfr_in_if.sink     in_chan,
  sfr_out_if.source  out_chan,
  sfr_cfg_if.sink    cfg_chan
);
  import sfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sfr_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_byte     (in_chan.text_byte),
    .in_line_end (in_chan.line_end),
    .in_empty    (in_chan.empty_line),
    .cfg         (cfg_chan),
    .dout        (out_chan)
  );

  a_finish_clears_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !sts.hold_full)
    else $error("hold stage not emptied after line close");

  a_accept_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |-> !sts.hold_full)
    else $error("new transfer taken with a result still held");

  a_line_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.line_done) |-> out_chan.last)
    else $error("line close not on final result");

  a_blank_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.byte_valid) |->
      (out_chan.out_byte == '0 && out_chan.line_done && out_chan.last))
    else $error("byteless result malformed");

endmodule
